// File: design/ntpd_pkg.sv
// Shared widths, constants, tables and types for the note to pitch and duration core.
package ntpd_pkg;

   localparam int DEG_W   = 4;
   localparam int ACC_W   = 3;
   localparam int OCT_W   = 3;
   localparam int DIV_W   = 8;
   localparam int DOT_W   = 32;
   localparam int KEY_W   = 5;
   localparam int WHOLE_W = 16;
   localparam int IDX_W   = 7;
   localparam int FREQ_W  = 14;
   localparam int DUR_W   = 17;
   localparam int SUM_W   = DUR_W + 1;
   localparam int PADDR_W = 3;
   localparam int PDATA_W = 32;

   localparam int DEGREE_MAX       = 7;
   localparam int DOT_BITS_DEFAULT = 32;
   // dots past this many shift a 16-bit base to zero
   localparam int BASE_DOTS        = WHOLE_W - 1;
   localparam int GROUP_SIZE       = 4;

   localparam logic [WHOLE_W-1:0] WHOLE_RESET = 16'd2000;

   localparam int IDX_OFFSET  = 72;
   // floor(u/12) == (u*171) >> 11 for u below 136
   localparam int RECIP_12    = 171;
   localparam int RECIP_SHIFT = 11;
   // right shift of the Q16.16 tone is 16 - (q - 6)
   localparam int SHIFT_BASE  = 22;

   localparam int FREQ_MAX  = 16383;
   localparam int FREQ_PEAK = 15804;
   localparam int DUR_MAX   = 131071;

   localparam int DIV_STAGES   = 4;
   localparam int DIV_STEP     = WHOLE_W / DIV_STAGES;
   localparam int PITCH_STAGES = 3;
   localparam int SUM_STAGES   = 2;

   typedef enum logic {
      REG_KEY_OFFSET = 1'b0,
      REG_WHOLE_NOTE = 1'b1
   } ntpd_reg_type;

   typedef struct packed {
      logic signed [IDX_W-1:0] pitch_index;
      logic [FREQ_W-1:0]       frequency_hz;
   } ntpd_pitch_type;

   function automatic int dot_use(input int bits);
      return (bits < BASE_DOTS) ? bits : BASE_DOTS;
   endfunction

   function automatic logic [3:0] semis_of(input logic [2:0] degree);
      logic [3:0] s;
      case (degree)
         3'd2:    s = 4'd2;
         3'd3:    s = 4'd4;
         3'd4:    s = 4'd5;
         3'd5:    s = 4'd7;
         3'd6:    s = 4'd9;
         3'd7:    s = 4'd11;
         default: s = 4'd0;
      endcase
      return s;
   endfunction

   // Q16.16 of 261.626 * 2^(s/12), middle C octave
   function automatic logic [24:0] tone_q16(input logic [3:0] semi);
      logic [24:0] t;
      case (semi)
         4'd0:    t = 25'd17145922;
         4'd1:    t = 25'd18165471;
         4'd2:    t = 25'd19245646;
         4'd3:    t = 25'd20390052;
         4'd4:    t = 25'd21602507;
         4'd5:    t = 25'd22887059;
         4'd6:    t = 25'd24247995;
         4'd7:    t = 25'd25689856;
         4'd8:    t = 25'd27217454;
         4'd9:    t = 25'd28835888;
         4'd10:   t = 25'd30550559;
         4'd11:   t = 25'd32367190;
         default: t = 25'd0;
      endcase
      return t;
   endfunction

endpackage

// File: design/ntpd_pitch.sv
// Pitch path: semitone index, octave split and tone table shift over three stages.
module ntpd_pitch (
   input  logic                                clock,
   input  logic [2:0]                          degree,
   input  logic                                rest,
   input  logic signed [ntpd_pkg::ACC_W-1:0]   accidental,
   input  logic signed [ntpd_pkg::OCT_W-1:0]   octave_shift,
   input  logic signed [ntpd_pkg::KEY_W-1:0]   key_offset,
   output ntpd_pkg::ntpd_pitch_type            pitch
);
   import ntpd_pkg::*;

   localparam logic signed [7:0] IDX_LOW  = -8'sd64;
   localparam logic signed [7:0] IDX_HIGH = 8'sd63;

   logic signed [7:0]       sum;
   logic signed [IDX_W-1:0] idx1_in, idx1_ff;

   logic [7:0]              u;
   logic [15:0]             prod;
   logic [3:0]              q;
   logic [3:0]              semi2_in, semi2_ff;
   logic [4:0]              sh2_in, sh2_ff;
   logic signed [IDX_W-1:0] idx2_ff;

   logic [24:0]             f;
   logic [FREQ_W-1:0]       freq3_in, freq3_ff;
   logic signed [IDX_W-1:0] idx3_ff;

   // stage 1: index sum and clamp
   always_comb begin
      sum = signed'({4'b0000, semis_of(degree)}) + 8'(accidental) + 8'(key_offset)
            + (8'(octave_shift) <<< 3) + (8'(octave_shift) <<< 2);
      if (rest) begin
         idx1_in = '0;
      end else if (sum < IDX_LOW) begin
         idx1_in = IDX_LOW[IDX_W-1:0];
      end else if (sum > IDX_HIGH) begin
         idx1_in = IDX_HIGH[IDX_W-1:0];
      end else begin
         idx1_in = sum[IDX_W-1:0];
      end
   end

   // stage 2: split into octave and semitone
   always_comb begin
      u        = 8'(8'(idx1_ff) + 8'(IDX_OFFSET));
      prod     = 16'(u) * 16'(RECIP_12);
      q        = prod[RECIP_SHIFT+3:RECIP_SHIFT];
      semi2_in = 4'(u - 8'({q, 3'b000}) - 8'({q, 2'b00}));
      sh2_in   = 5'(SHIFT_BASE) - {1'b0, q};
   end

   // stage 3: table and shift
   always_comb begin
      f = tone_q16(semi2_ff) >> sh2_ff;
      if (f > 25'(FREQ_MAX)) begin
         freq3_in = FREQ_W'(FREQ_MAX);
      end else begin
         freq3_in = f[FREQ_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      idx1_ff  <= idx1_in;
      semi2_ff <= semi2_in;
      sh2_ff   <= sh2_in;
      idx2_ff  <= idx1_ff;
      freq3_ff <= freq3_in;
      idx3_ff  <= idx2_ff;
   end

   assign pitch.pitch_index  = idx3_ff;
   assign pitch.frequency_hz = freq3_ff;

endmodule

// File: design/ntpd_divider.sv
// Pipelined restoring divider, whole-note time over note division.
module ntpd_divider (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   input  logic [ntpd_pkg::WHOLE_W-1:0]     dividend,
   input  logic [ntpd_pkg::DIV_W-1:0]       divisor,
   output logic                             out_valid,
   output logic [ntpd_pkg::WHOLE_W-1:0]     quotient
);
   import ntpd_pkg::*;

   localparam int LAST = DIV_STAGES - 1;

   logic                vld_ff [DIV_STAGES];
   logic [DIV_W-1:0]    rem_ff [DIV_STAGES];
   logic [DIV_W-1:0]    dsr_ff [DIV_STAGES];
   logic [WHOLE_W-1:0]  acc_ff [DIV_STAGES];

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
      logic               vld_src;
      logic [DIV_W-1:0]   rem_src, dsr_src, rem_in;
      logic [WHOLE_W-1:0] acc_src, acc_in;

      if (s == 0) begin : g_first
         assign vld_src = in_valid;
         assign rem_src = '0;
         assign dsr_src = divisor;
         assign acc_src = dividend;
      end else begin : g_next
         assign vld_src = vld_ff[s-1];
         assign rem_src = rem_ff[s-1];
         assign dsr_src = dsr_ff[s-1];
         assign acc_src = acc_ff[s-1];
      end

      always_comb begin : p_steps
         logic [DIV_W:0]     wide;
         logic [DIV_W-1:0]   rem_w;
         logic [WHOLE_W-1:0] acc_w;
         rem_w = rem_src;
         acc_w = acc_src;
         for (int i = 0; i < DIV_STEP; i++) begin
            wide  = {rem_w, acc_w[WHOLE_W-1]};
            acc_w = {acc_w[WHOLE_W-2:0], 1'b0};
            if (wide >= {1'b0, dsr_src}) begin
               rem_w    = DIV_W'(wide - {1'b0, dsr_src});
               acc_w[0] = 1'b1;
            end else begin
               rem_w = wide[DIV_W-1:0];
            end
         end
         rem_in = rem_w;
         acc_in = acc_w;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else begin
            vld_ff[s] <= vld_src;
         end
         rem_ff[s] <= rem_in;
         dsr_ff[s] <= dsr_src;
         acc_ff[s] <= acc_in;
      end
   end

   assign out_valid = vld_ff[LAST];
   assign quotient  = acc_ff[LAST];

   a_latency: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> $past(in_valid, DIV_STAGES))
      else $error("divider output without matching input");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (out_valid && dsr_ff[LAST] != '0) |-> (rem_ff[LAST] < dsr_ff[LAST]))
      else $error("divider remainder not below divisor");

   a_identity: assert property (@(posedge clock) disable iff (reset)
      (out_valid && dsr_ff[LAST] != '0) |->
         (24'(quotient) * 24'(dsr_ff[LAST]) + 24'(rem_ff[LAST])
          == 24'($past(dividend, DIV_STAGES))))
      else $error("divider quotient and remainder do not rebuild dividend");

endmodule

// File: design/ntpd_dots.sv
// Dot extension sum: base plus shifted copies, two-level registered adder tree.
module ntpd_dots #(
   parameter int DOT_BITS = ntpd_pkg::DOT_BITS_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     in_valid,
   input  logic [ntpd_pkg::WHOLE_W-1:0]             base,
   input  logic [ntpd_pkg::dot_use(DOT_BITS)-1:0]   dots,
   output logic                                     out_valid,
   output logic [ntpd_pkg::DUR_W-1:0]               duration
);
   import ntpd_pkg::*;

   localparam int DOT_USE = dot_use(DOT_BITS);
   localparam int TERMS   = BASE_DOTS + 1;
   localparam int GROUPS  = TERMS / GROUP_SIZE;

   logic [WHOLE_W-1:0] term [TERMS];
   logic [SUM_W-1:0]   grp_in [GROUPS];
   logic [SUM_W-1:0]   grp_ff [GROUPS];
   logic               vld1_ff, vld2_ff;
   logic [SUM_W-1:0]   total;
   logic [DUR_W-1:0]   dur_in, dur_ff;

   assign term[0] = base;

   for (genvar k = 1; k < TERMS; k++) begin : g_term
      if (k <= DOT_USE) begin : g_used
         assign term[k] = dots[k-1] ? (base >> k) : '0;
      end else begin : g_unused
         assign term[k] = '0;
      end
   end

   always_comb begin
      for (int g = 0; g < GROUPS; g++) begin
         grp_in[g] = '0;
         for (int j = 0; j < GROUP_SIZE; j++) begin
            grp_in[g] = grp_in[g] + SUM_W'(term[g*GROUP_SIZE+j]);
         end
      end
   end

   always_comb begin
      total = '0;
      for (int g = 0; g < GROUPS; g++) begin
         total = total + grp_ff[g];
      end
      if (total > SUM_W'(DUR_MAX)) begin
         dur_in = DUR_W'(DUR_MAX);
      end else begin
         dur_in = total[DUR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
      end else begin
         vld1_ff <= in_valid;
         vld2_ff <= vld1_ff;
      end
      grp_ff <= grp_in;
      dur_ff <= dur_in;
   end

   assign out_valid = vld2_ff;
   assign duration  = dur_ff;

endmodule

// File: design/note_to_pitch_and_duration_core.sv
// Top level of the note to pitch and duration core: registers, input stage, alignment, output.
// One note is taken in every clock cycle (busy never rises) and its result appears on the
// rsp_ ports from the output register, held for one cycle with rsp_valid high; the
// receiver cannot stall. The depth is set by the four-stage divider for the base duration
// followed by the two-stage dot adder tree; the pitch path is shorter and is delayed to match.
// Degrees above seven are taken but give no result. Registers: key offset at byte address 0,
// whole-note time at byte address 4; change them only while no note is in flight.
module note_to_pitch_and_duration_core #(
   parameter int DOT_BITS = ntpd_pkg::DOT_BITS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic [ntpd_pkg::DEG_W-1:0]             req_scale_degree,
   input  logic signed [ntpd_pkg::ACC_W-1:0]      req_accidental,
   input  logic signed [ntpd_pkg::OCT_W-1:0]      req_octave_shift,
   input  logic [ntpd_pkg::DIV_W-1:0]             req_note_division,
   input  logic [ntpd_pkg::DOT_W-1:0]             req_dot_mask,
   output logic                                   rsp_valid,
   output logic                                   rsp_is_rest,
   output logic signed [ntpd_pkg::IDX_W-1:0]      rsp_pitch_index,
   output logic [ntpd_pkg::FREQ_W-1:0]            rsp_frequency_hz,
   output logic [ntpd_pkg::DUR_W-1:0]             rsp_duration_ms,
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [ntpd_pkg::PADDR_W-1:0]           paddr,
   input  logic [ntpd_pkg::PDATA_W-1:0]           pwdata,
   output logic [ntpd_pkg::PDATA_W-1:0]           prdata,
   output logic                                   pready
);
   import ntpd_pkg::*;

   localparam int DOT_USE   = dot_use(DOT_BITS);
   localparam int SIDE_LEN  = DIV_STAGES + SUM_STAGES;
   localparam int PITCH_DLY = SIDE_LEN - PITCH_STAGES;
   localparam int LATENCY   = SIDE_LEN + 2;

   // configuration
   logic signed [KEY_W-1:0] key_offset_ff;
   logic [WHOLE_W-1:0]      whole_note_ff;
   logic                    cfg_write;
   ntpd_reg_type            reg_sel;

   // input stage
   logic                    take;
   logic                    vld0_in, vld0_ff;
   logic                    rest0_ff, zero0_ff;
   logic [2:0]              deg0_ff;
   logic signed [ACC_W-1:0] acc0_ff;
   logic signed [OCT_W-1:0] oct0_ff;
   logic [DIV_W-1:0]        div0_ff;
   logic [DOT_USE-1:0]      dots0_ff;

   // alignment
   logic                    rest_dl_ff [SIDE_LEN];
   logic                    zero_dl_ff [SIDE_LEN];
   logic [DOT_USE-1:0]      dots_dl_ff [DIV_STAGES];
   ntpd_pitch_type          pitch;
   ntpd_pitch_type          pitch_dl_ff [PITCH_DLY];

   logic                    q_valid;
   logic [WHOLE_W-1:0]      quotient;
   logic                    sum_valid;
   logic [DUR_W-1:0]        dur_sum;

   // output stage
   logic                    rsp_valid_ff;
   logic                    rsp_is_rest_ff;
   logic signed [IDX_W-1:0] rsp_idx_ff;
   logic [FREQ_W-1:0]       rsp_freq_ff;
   logic [DUR_W-1:0]        rsp_dur_ff;

   assign pready    = 1'b1;
   assign busy      = 1'b0;
   assign cfg_write = psel & penable & pwrite & pready;
   assign reg_sel   = ntpd_reg_type'(paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         key_offset_ff <= '0;
         whole_note_ff <= WHOLE_RESET;
      end else if (cfg_write) begin
         case (reg_sel)
            REG_KEY_OFFSET: key_offset_ff <= pwdata[KEY_W-1:0];
            REG_WHOLE_NOTE: whole_note_ff <= pwdata[WHOLE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_KEY_OFFSET: prdata = PDATA_W'(key_offset_ff);
         REG_WHOLE_NOTE: prdata = PDATA_W'(whole_note_ff);
         default:        prdata = '0;
      endcase
   end

   assign take    = start & ~busy;
   assign vld0_in = take && (req_scale_degree <= DEG_W'(DEGREE_MAX));

   always_ff @(posedge clock) begin
      if (reset) begin
         vld0_ff <= 1'b0;
      end else begin
         vld0_ff <= vld0_in;
      end
      rest0_ff <= (req_scale_degree == '0);
      zero0_ff <= (req_note_division == '0);
      deg0_ff  <= req_scale_degree[2:0];
      acc0_ff  <= req_accidental;
      oct0_ff  <= req_octave_shift;
      div0_ff  <= req_note_division;
      dots0_ff <= req_dot_mask[DOT_USE-1:0];
   end

   ntpd_pitch u_pitch (
      .clock        (clock),
      .degree       (deg0_ff),
      .rest         (rest0_ff),
      .accidental   (acc0_ff),
      .octave_shift (oct0_ff),
      .key_offset   (key_offset_ff),
      .pitch        (pitch)
   );

   ntpd_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vld0_ff),
      .dividend  (whole_note_ff),
      .divisor   (div0_ff),
      .out_valid (q_valid),
      .quotient  (quotient)
   );

   ntpd_dots #(
      .DOT_BITS (DOT_BITS)
   ) u_dots (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_valid),
      .base      (quotient),
      .dots      (dots_dl_ff[DIV_STAGES-1]),
      .out_valid (sum_valid),
      .duration  (dur_sum)
   );

   always_ff @(posedge clock) begin
      rest_dl_ff[0]  <= rest0_ff;
      zero_dl_ff[0]  <= zero0_ff;
      dots_dl_ff[0]  <= dots0_ff;
      pitch_dl_ff[0] <= pitch;
      for (int i = 1; i < SIDE_LEN; i++) begin
         rest_dl_ff[i] <= rest_dl_ff[i-1];
         zero_dl_ff[i] <= zero_dl_ff[i-1];
      end
      for (int i = 1; i < DIV_STAGES; i++) begin
         dots_dl_ff[i] <= dots_dl_ff[i-1];
      end
      for (int i = 1; i < PITCH_DLY; i++) begin
         pitch_dl_ff[i] <= pitch_dl_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= sum_valid;
      end
      rsp_is_rest_ff <= rest_dl_ff[SIDE_LEN-1];
      rsp_idx_ff     <= rest_dl_ff[SIDE_LEN-1] ? '0 : pitch_dl_ff[PITCH_DLY-1].pitch_index;
      rsp_freq_ff    <= rest_dl_ff[SIDE_LEN-1] ? '0 : pitch_dl_ff[PITCH_DLY-1].frequency_hz;
      rsp_dur_ff     <= zero_dl_ff[SIDE_LEN-1] ? DUR_W'(DUR_MAX) : dur_sum;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_is_rest      = rsp_is_rest_ff;
   assign rsp_pitch_index  = rsp_idx_ff;
   assign rsp_frequency_hz = rsp_freq_ff;
   assign rsp_duration_ms  = rsp_dur_ff;

   a_result_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy && req_scale_degree <= DEG_W'(DEGREE_MAX), LATENCY))
      else $error("result without a matching note transfer");

   a_tone_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_is_rest) |-> (rsp_frequency_hz != '0))
      else $error("sounding note with zero frequency");

   a_tone_peak: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_frequency_hz <= FREQ_W'(FREQ_PEAK)))
      else $error("frequency above top of table");

endmodule

// File: verif/note_result_checker.sv
`timescale 1ns / 100ps
// Checker for the note core: predicts pitch, frequency and duration per note and compares results.
module note_result_checker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic                                   busy,
   input  logic [ntpd_pkg::DEG_W-1:0]             req_scale_degree,
   input  logic signed [ntpd_pkg::ACC_W-1:0]      req_accidental,
   input  logic signed [ntpd_pkg::OCT_W-1:0]      req_octave_shift,
   input  logic [ntpd_pkg::DIV_W-1:0]             req_note_division,
   input  logic [ntpd_pkg::DOT_W-1:0]             req_dot_mask,
   input  logic                                   rsp_valid,
   input  logic                                   rsp_is_rest,
   input  logic signed [ntpd_pkg::IDX_W-1:0]      rsp_pitch_index,
   input  logic [ntpd_pkg::FREQ_W-1:0]            rsp_frequency_hz,
   input  logic [ntpd_pkg::DUR_W-1:0]             rsp_duration_ms,
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [ntpd_pkg::PADDR_W-1:0]           paddr,
   input  logic [ntpd_pkg::PDATA_W-1:0]           pwdata,
   input  logic                                   pready,
   output int                                     fail_count,
   output int                                     pending
);
   import ntpd_pkg::*;

   localparam int SEMIS_PER_OCTAVE = 12;
   localparam int OCTAVE_BIAS      = 6;
   localparam int Q_FRAC           = 16;
   localparam int IDX_LOW          = -64;
   localparam int IDX_HIGH         = 63;

   localparam int SEMITONE_OF [8] = '{0, 0, 2, 4, 5, 7, 9, 11};
   localparam longint TONE_Q16 [12] = '{
      17145922, 18165471, 19245646, 20390052, 21602507, 22887059,
      24247995, 25689856, 27217454, 28835888, 30550559, 32367190
   };

   typedef struct packed {
      logic                    is_rest;
      logic signed [IDX_W-1:0] pitch_index;
      logic [FREQ_W-1:0]       frequency_hz;
      logic [DUR_W-1:0]        duration_ms;
   } note_result_type;

   logic signed [KEY_W-1:0] key_offset;
   logic [WHOLE_W-1:0]      whole_note_ms;
   note_result_type         expected_notes [$];

   function automatic bit predict_note(input logic [DEG_W-1:0] degree,
                                       input logic signed [ACC_W-1:0] acc,
                                       input logic signed [OCT_W-1:0] octv,
                                       input logic [DIV_W-1:0] div,
                                       input logic [DOT_W-1:0] dots,
                                       output note_result_type res);
      int     idx;
      int     u;
      int     oct_shift;
      longint tone;
      longint freq;
      longint base;
      longint dur;
      res  = '0;
      idx  = 0;
      freq = 0;
      if (degree > DEGREE_MAX) return 1'b0;
      if (degree != '0) begin
         idx = SEMITONE_OF[degree[2:0]] + int'(acc) + int'(key_offset)
               + int'(octv) * SEMIS_PER_OCTAVE;
         if (idx < IDX_LOW) idx = IDX_LOW;
         if (idx > IDX_HIGH) idx = IDX_HIGH;
         u         = idx + IDX_OFFSET;
         oct_shift = u / SEMIS_PER_OCTAVE - OCTAVE_BIAS;
         tone      = TONE_Q16[u % SEMIS_PER_OCTAVE];
         if (oct_shift >= 0) freq = (tone << oct_shift) >> Q_FRAC;
         else freq = tone >> (Q_FRAC - oct_shift);
         if (freq > FREQ_MAX) freq = FREQ_MAX;
      end
      if (div == '0) begin
         dur = DUR_MAX;
      end else begin
         base = longint'(whole_note_ms) / longint'(div);
         dur  = base;
         for (int i = 0; i < DOT_W; i++) begin
            if (dots[i]) dur += base >> (i + 1);
         end
         if (dur > DUR_MAX) dur = DUR_MAX;
      end
      res.is_rest      = (degree == '0);
      res.pitch_index  = idx[IDX_W-1:0];
      res.frequency_hz = freq[FREQ_W-1:0];
      res.duration_ms  = dur[DUR_W-1:0];
      return 1'b1;
   endfunction

   always @(posedge clock) begin : watch
      note_result_type want;
      if (reset) begin
         expected_notes.delete();
         key_offset    <= '0;
         whole_note_ms <= WHOLE_RESET;
         pending       <= 0;
      end else begin
         if (start && !busy) begin
            if (predict_note(req_scale_degree, req_accidental, req_octave_shift,
                             req_note_division, req_dot_mask, want))
               expected_notes.push_back(want);
         end
         if (rsp_valid) begin
            if (expected_notes.size() == 0) begin
               $error("result transfer with nothing expected");
               fail_count++;
            end else begin
               want = expected_notes.pop_front();
               if (rsp_is_rest !== want.is_rest) begin
                  $error("is_rest: expected %0d, got %0d", want.is_rest, rsp_is_rest);
                  fail_count++;
               end
               if (rsp_pitch_index !== want.pitch_index) begin
                  $error("pitch_index: expected %0d, got %0d",
                         want.pitch_index, rsp_pitch_index);
                  fail_count++;
               end
               if (rsp_frequency_hz !== want.frequency_hz) begin
                  $error("frequency_hz: expected %0d, got %0d",
                         want.frequency_hz, rsp_frequency_hz);
                  fail_count++;
               end
               if (rsp_duration_ms !== want.duration_ms) begin
                  $error("duration_ms: expected %0d, got %0d",
                         want.duration_ms, rsp_duration_ms);
                  fail_count++;
               end
            end
         end
         if (psel && penable && pwrite && pready) begin
            case (ntpd_reg_type'(paddr[2]))
               REG_KEY_OFFSET: key_offset    <= pwdata[KEY_W-1:0];
               REG_WHOLE_NOTE: whole_note_ms <= pwdata[WHOLE_W-1:0];
               default: ;
            endcase
         end
         pending <= expected_notes.size();
      end
   end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps
// Top of the note core testbench: clock, reset, note and register stimulus, watchdog and verdict.
module testbench;
   import ntpd_pkg::*;

   localparam int PHASES        = 8;
   localparam int PHASE_NOTES   = 200;
   localparam int SETTLE_CYCLES = 12;
   localparam int QUIET_LIMIT   = 2000;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      start;
   logic                      busy;
   logic [DEG_W-1:0]          req_scale_degree;
   logic signed [ACC_W-1:0]   req_accidental;
   logic signed [OCT_W-1:0]   req_octave_shift;
   logic [DIV_W-1:0]          req_note_division;
   logic [DOT_W-1:0]          req_dot_mask;
   logic                      rsp_valid;
   logic                      rsp_is_rest;
   logic signed [IDX_W-1:0]   rsp_pitch_index;
   logic [FREQ_W-1:0]         rsp_frequency_hz;
   logic [DUR_W-1:0]          rsp_duration_ms;
   logic                      psel;
   logic                      penable;
   logic                      pwrite;
   logic [PADDR_W-1:0]        paddr;
   logic [PDATA_W-1:0]        pwdata;
   logic [PDATA_W-1:0]        prdata;
   logic                      pready;
   int                        fail_count;
   int                        pending;
   int                        quiet_cycles = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   note_to_pitch_and_duration_core u_top (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_scale_degree  (req_scale_degree),
      .req_accidental    (req_accidental),
      .req_octave_shift  (req_octave_shift),
      .req_note_division (req_note_division),
      .req_dot_mask      (req_dot_mask),
      .rsp_valid         (rsp_valid),
      .rsp_is_rest       (rsp_is_rest),
      .rsp_pitch_index   (rsp_pitch_index),
      .rsp_frequency_hz  (rsp_frequency_hz),
      .rsp_duration_ms   (rsp_duration_ms),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   note_result_checker u_check (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_scale_degree  (req_scale_degree),
      .req_accidental    (req_accidental),
      .req_octave_shift  (req_octave_shift),
      .req_note_division (req_note_division),
      .req_dot_mask      (req_dot_mask),
      .rsp_valid         (rsp_valid),
      .rsp_is_rest       (rsp_is_rest),
      .rsp_pitch_index   (rsp_pitch_index),
      .rsp_frequency_hz  (rsp_frequency_hz),
      .rsp_duration_ms   (rsp_duration_ms),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .pready            (pready),
      .fail_count        (fail_count),
      .pending           (pending)
   );

   // called just after a rising edge; returns just after the edge that took the transfer
   task automatic send_note(input int deg, input int acc, input int octv, input int div,
                            input logic [DOT_W-1:0] dots);
      logic taken;
      start             <= 1'b1;
      req_scale_degree  <= DEG_W'(deg);
      req_accidental    <= ACC_W'(acc);
      req_octave_shift  <= OCT_W'(octv);
      req_note_division <= DIV_W'(div);
      req_dot_mask      <= dots;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = !busy;
         @(posedge clock);
      end
   endtask

   task automatic send_random_note(input int idle_pct);
      int               deg;
      int               div;
      logic [DOT_W-1:0] dots;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      if ($urandom_range(99) < 12) deg = int'($urandom_range(15, 8));
      else deg = int'($urandom_range(7, 0));
      case ($urandom_range(9))
         0:         div = 0;
         1, 2, 3:   div = int'($urandom_range(8, 1));
         default:   div = int'($urandom_range(255, 0));
      endcase
      case ($urandom_range(3))
         0:       dots = '0;
         1:       dots = $urandom;
         2:       dots = 32'd1 << $urandom_range(31, 0);
         default: dots = '1;
      endcase
      send_note(deg, int'($urandom_range(7, 0)), int'($urandom_range(7, 0)), div, dots);
   endtask

   task automatic write_reg(input ntpd_reg_type sel, input logic [PDATA_W-1:0] value);
      logic done;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {sel, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      done = 1'b0;
      while (!done) begin
         @(negedge clock);
         done = pready;
         @(posedge clock);
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // notes with degree above seven still pass through the pipe, hence the settle
   task automatic wait_drained();
      do @(posedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (psel && penable)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("note_to_pitch_and_duration_core test failed");
            $finish;
         end
      end
   end

   initial begin
      int key_val;
      int whole_val;
      int idle_pct;
      reset             = 1'b1;
      start             = 1'b0;
      req_scale_degree  = '0;
      req_accidental    = '0;
      req_octave_shift  = '0;
      req_note_division = '0;
      req_dot_mask      = '0;
      psel              = 1'b0;
      penable           = 1'b0;
      pwrite            = 1'b0;
      paddr             = '0;
      pwdata            = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed notes at reset register values
      send_note(0, 0, 0, 4, '0);
      send_note(1, 0, 0, 1, '0);
      send_note(2, 1, 0, 2, 32'd1);
      send_note(3, -1, 0, 4, 32'd3);
      send_note(4, 0, 1, 8, '0);
      send_note(5, 2, -1, 16, '0);
      send_note(6, -2, 2, 3, '1);
      send_note(7, 0, 0, 255, '0);
      send_note(8, 0, 0, 4, '0);
      send_note(15, 3, 3, 255, '1);
      send_note(1, -4, -4, 1, '0);
      send_note(7, 3, 3, 1, '1);
      send_note(0, 3, -4, 0, '1);
      send_note(4, 0, 0, 0, '0);
      send_note(7, 0, -3, 2, 32'h8000_0000);
      send_note(1, 0, 3, 5, 32'h0000_FFFF);
      send_note(3, -4, -3, 7, 32'hAAAA_5555);
      send_note(6, 3, 2, 128, 32'h0000_0001);
      send_note(0, 0, 0, 1, '1);
      send_note(2, 0, -1, 12, 32'h0001_0000);

      for (int p = 0; p < PHASES; p++) begin
         case (p % 3)
            0:       idle_pct = 0;
            1:       idle_pct = 84;
            default: idle_pct = 9;
         endcase
         if (p != 0) begin
            case (p)
               1:       begin key_val = -11; whole_val = 65535; end
               2:       begin key_val = 11;  whole_val = 1;     end
               3:       begin key_val = -16; whole_val = 0;     end
               4:       begin key_val = 15;  whole_val = 65535; end
               5:       begin key_val = $urandom_range(31, 0); whole_val = $urandom_range(64, 1); end
               6:       begin key_val = $urandom_range(31, 0); whole_val = $urandom_range(65535, 1); end
               default: begin key_val = 0;   whole_val = 2000;  end
            endcase
            start <= 1'b0;
            wait_drained();
            write_reg(REG_KEY_OFFSET, key_val);
            @(posedge clock);
            write_reg(REG_WHOLE_NOTE, whole_val);
            @(posedge clock);
            // lowest and highest pitch sums under the new key
            send_note(1, -4, -4, 1, '0);
            send_note(7, 3, 3, 1, '1);
         end
         for (int n = 0; n < PHASE_NOTES; n++) send_random_note(idle_pct);
      end

      start <= 1'b0;
      wait_drained();
      if (fail_count == 0 && pending == 0) begin
         $display("note_to_pitch_and_duration_core test passed");
      end else begin
         $display("note_to_pitch_and_duration_core test failed");
      end
      $finish;
   end

endmodule
